// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file psc_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is asserted.
`define PSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// A value must hold over the cycle after cond.
`define PSC_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("held value changed");

`endif

// ===== rtl/psc_pkg.sv =====
// ---------------------------------------------------------------------------
// psc_pkg
// Types, codes and sizes shared by the stack calculator.
// ---------------------------------------------------------------------------
package psc_pkg;

	localparam int DATA_W          = 32;
	localparam int OP_W            = 3;
	localparam int STAT_W          = 3;
	localparam int DEPTH_OUT_W     = 7;
	localparam int IN_TDATA_W      = 40;
	localparam int OUT_TDATA_W     = 48;
	localparam int DEF_STACK_DEPTH = 64;
	localparam int DEF_QUEUE_DEPTH = 2;

	// token codes
	localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OP_W-1:0] OP_POW  = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DIVZERO   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_ZERONEG   = 3'd4;

	typedef enum logic [2:0] {
		K_PUSH,
		K_ADD,
		K_SUB,
		K_MUL,
		K_DIV,
		K_POW,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] number;
	} item_t;

	typedef struct packed {
		logic              start;
		logic              pow;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mdu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} mdu_rsp_t;

endpackage

// ===== rtl/psc_ram.sv =====
// ---------------------------------------------------------------------------
// psc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module psc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/psc_front.sv =====
// ---------------------------------------------------------------------------
// psc_front
// Input stage: takes tokens, decodes the kind and registers the item.
// ---------------------------------------------------------------------------
module psc_front import psc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	output logic                  item_valid,
	input  logic                  item_ready,
	output item_t                 item
);

	logic              vld_s1;
	item_t             item_s1;
	kind_t             kind;
	logic [OP_W-1:0]   op;

	assign op = s_axis_tdata[OP_W-1:0];

	always_comb begin
		unique case (op)
			OP_PUSH: kind = K_PUSH;
			OP_ADD:  kind = K_ADD;
			OP_SUB:  kind = K_SUB;
			OP_MUL:  kind = K_MUL;
			OP_DIV:  kind = K_DIV;
			OP_POW:  kind = K_POW;
			default: kind = K_NOP;
		endcase
	end

	assign s_axis_tready = !vld_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind   <= kind;
			item_s1.number <= s_axis_tdata[OP_W +: DATA_W];
		end
	end

	assign item_valid = vld_s1;
	assign item       = item_s1;

endmodule

// ===== rtl/psc_queue.sv =====
// ---------------------------------------------------------------------------
// psc_queue
// Small FIFO of decoded items between front and back.
// ---------------------------------------------------------------------------
module psc_queue import psc_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop,
	output item_t pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/psc_mdu.sv =====
// ---------------------------------------------------------------------------
// psc_mdu
// Shared iterative unit: restoring divide and square-and-multiply power.
// ---------------------------------------------------------------------------
module psc_mdu import psc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mdu_req_t req,
	output mdu_rsp_t rsp
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_DIV,
		M_POW,
		M_FIX,
		M_DONE
	} mstate_t;

	localparam int CNT_W = $clog2(DATA_W);

	mstate_t           state_q;
	logic [DATA_W-1:0] acc_q;   // quotient or running product
	logic [DATA_W-1:0] base_q;  // divisor or squared base
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] exp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;

	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;
	logic              na;
	logic              nb;
	logic [DATA_W-1:0] ma;
	logic [DATA_W-1:0] mb;
	logic [DATA_W-1:0] neg_pow;

	assign rem_sh = {rem_q, acc_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, base_q};
	assign na     = req.a[DATA_W-1];
	assign nb     = req.b[DATA_W-1];
	assign ma     = na ? (DATA_W'(0) - req.a) : req.a;
	assign mb     = nb ? (DATA_W'(0) - req.b) : req.b;

	// negative exponent: exact result truncated toward zero
	always_comb begin
		priority if (req.a == DATA_W'(1)) begin
			neg_pow = DATA_W'(1);
		end else if (req.a == '1) begin
			neg_pow = req.b[0] ? '1 : DATA_W'(1);
		end else begin
			neg_pow = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			acc_q   <= '0;
			base_q  <= '0;
			rem_q   <= '0;
			exp_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				M_IDLE: begin
					if (req.start && req.pow) begin
						if (req.b[DATA_W-1]) begin
							acc_q   <= neg_pow;
							state_q <= M_DONE;
						end else begin
							acc_q   <= DATA_W'(1);
							base_q  <= req.a;
							exp_q   <= req.b;
							state_q <= M_POW;
						end
					end else if (req.start) begin
						acc_q   <= ma;
						base_q  <= mb;
						rem_q   <= '0;
						cnt_q   <= '0;
						neg_q   <= na ^ nb;
						state_q <= M_DIV;
					end
				end
				M_DIV: begin
					if (!diff[DATA_W]) begin
						rem_q <= diff[DATA_W-1:0];
						acc_q <= {acc_q[DATA_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[DATA_W-1:0];
						acc_q <= {acc_q[DATA_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DATA_W - 1)) begin
						state_q <= M_FIX;
					end
				end
				M_POW: begin
					if (exp_q == '0) begin
						state_q <= M_DONE;
					end else begin
						if (exp_q[0]) begin
							acc_q <= acc_q * base_q;
						end
						base_q <= base_q * base_q;
						exp_q  <= exp_q >> 1;
					end
				end
				M_FIX: begin
					if (neg_q) begin
						acc_q <= DATA_W'(0) - acc_q;
					end
					state_q <= M_DONE;
				end
				M_DONE: begin
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign rsp.done   = (state_q == M_DONE);
	assign rsp.result = acc_q;

endmodule

// ===== rtl/psc_back.sv =====
// ---------------------------------------------------------------------------
// psc_back
// Executes items against the stack and registers one result per item.
// ---------------------------------------------------------------------------
module psc_back import psc_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_pop,
	input  item_t                  item,
	output mdu_req_t               mdu_req,
	input  mdu_rsp_t               mdu_rsp,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_EXEC,
		B_WAIT,
		B_COMMIT,
		B_RESULT
	} bstate_t;

	bstate_t                  state_q;
	logic [SP_W-1:0]          sp_q;
	logic [DATA_W-1:0]        top_q;  // top entry lives here, the rest in RAM
	item_t                    item_q;
	logic [DATA_W-1:0]        a_q;
	logic [DATA_W-1:0]        res_q;
	logic [STAT_W-1:0]        stat_q;
	logic                     out_vld_q;
	logic [OUT_TDATA_W-1:0]   out_q;

	logic                     full;
	logic                     short;
	logic                     ram_we;
	logic [DATA_W-1:0]        ram_rdata;
	logic                     div_zero;
	logic                     zero_neg;
	logic [DATA_W-1:0]        top_out;
	logic                     out_load;

	assign full     = (sp_q == SP_W'(STACK_DEPTH));
	assign short    = (sp_q < SP_W'(2));
	assign item_pop = (state_q == B_IDLE) && item_valid;
	assign ram_we   = item_pop && (item.kind == K_PUSH) && !full && (sp_q != '0);
	assign div_zero = (top_q == '0);
	assign zero_neg = (a_q == '0) && top_q[DATA_W-1];
	assign top_out  = (sp_q == '0) ? '0 : top_q;
	assign out_load = (state_q == B_RESULT) && (!out_vld_q || m_axis_tready);

	psc_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(sp_q - SP_W'(1))),
		.wdata(top_q),
		.raddr(AW'(sp_q - SP_W'(2))),
		.rdata(ram_rdata)
	);

	assign mdu_req.start = (state_q == B_EXEC) &&
		(((item_q.kind == K_DIV) && !div_zero) || ((item_q.kind == K_POW) && !zero_neg));
	assign mdu_req.pow   = (item_q.kind == K_POW);
	assign mdu_req.a     = a_q;
	assign mdu_req.b     = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			sp_q      <= '0;
			top_q     <= '0;
			item_q    <= '0;
			a_q       <= '0;
			res_q     <= '0;
			stat_q    <= STAT_OK;
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_q     <= {{(OUT_TDATA_W - DATA_W - DEPTH_OUT_W - STAT_W){1'b0}},
					stat_q, DEPTH_OUT_W'(sp_q), top_out};
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (item_valid) begin
						item_q <= item;
						unique case (item.kind)
							K_PUSH: begin
								if (full) begin
									stat_q <= STAT_OVERFLOW;
								end else begin
									stat_q <= STAT_OK;
									top_q  <= item.number;
									sp_q   <= sp_q + SP_W'(1);
								end
								state_q <= B_RESULT;
							end
							K_NOP: begin
								stat_q  <= STAT_OK;
								state_q <= B_RESULT;
							end
							default: begin
								if (short) begin
									stat_q  <= STAT_UNDERFLOW;
									state_q <= B_RESULT;
								end else begin
									stat_q  <= STAT_OK;
									state_q <= B_READ;
								end
							end
						endcase
					end
				end
				B_READ: begin
					a_q     <= ram_rdata;
					state_q <= B_EXEC;
				end
				B_EXEC: begin
					unique case (item_q.kind)
						K_ADD: begin
							res_q   <= a_q + top_q;
							state_q <= B_COMMIT;
						end
						K_SUB: begin
							res_q   <= a_q - top_q;
							state_q <= B_COMMIT;
						end
						K_MUL: begin
							res_q   <= a_q * top_q;
							state_q <= B_COMMIT;
						end
						K_DIV: begin
							if (div_zero) begin
								stat_q  <= STAT_DIVZERO;
								state_q <= B_RESULT;
							end else begin
								state_q <= B_WAIT;
							end
						end
						K_POW: begin
							if (zero_neg) begin
								stat_q  <= STAT_ZERONEG;
								state_q <= B_RESULT;
							end else begin
								state_q <= B_WAIT;
							end
						end
						default: begin
							state_q <= B_RESULT;
						end
					endcase
				end
				B_WAIT: begin
					if (mdu_rsp.done) begin
						res_q   <= mdu_rsp.result;
						state_q <= B_COMMIT;
					end
				end
				B_COMMIT: begin
					top_q   <= res_q;
					sp_q    <= sp_q - SP_W'(1);
					state_q <= B_RESULT;
				end
				B_RESULT: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/postfix_integer_stack_calculator.sv =====
// ---------------------------------------------------------------------------
// postfix_integer_stack_calculator
// Postfix calculator on a stack of signed 32-bit integers.
// ---------------------------------------------------------------------------
// Each input item is one token: push a number, or add, subtract, multiply,
// divide or power on the two top entries (b on top, a beneath; a op b is
// pushed back). Every item gives exactly one result item with the new top
// of stack (zero when empty), the depth (low 7 bits of the entry count) and
// a status: ok, underflow, overflow, divide by zero or zero to a negative
// power. On any error the stack is left as it was; unused op codes leave it
// alone and report ok. A front stage decodes tokens into a short queue, so
// items are taken one per cycle until the queue fills; the back end then
// works through one item at a time. Push, unused code or underflow go
// straight to the result; add/subtract/multiply read the RAM, execute and
// commit; divide by zero or zero to a negative power stop after execute;
// divide and power wait on the shared unit, power by exponent length (a
// negative exponent needs no iteration); its 32-step divide sets the worst
// case. A stalled output adds its stall to the item waiting to leave. The
// stack sits in a RAM with the top entry held in a register, so an
// operator costs one RAM read. No clearing pass after reset is needed.
module postfix_integer_stack_calculator import psc_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op[2:0], number[34:3]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // top_value[31:0], depth[38:32],
	                                               // status[41:39]
);

	// front to queue
	logic     fr_valid;
	logic     fr_ready;
	item_t    fr_item;
	// queue to back
	logic     q_valid;
	logic     q_pop;
	item_t    q_item;
	// back to shared divide/power unit
	mdu_req_t mdu_req;
	mdu_rsp_t mdu_rsp;

	psc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.item_valid   (fr_valid),
		.item_ready   (fr_ready),
		.item         (fr_item)
	);

	psc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_item (fr_item),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_item  (q_item)
	);

	// stack, sequencing and result register
	psc_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (q_valid),
		.item_pop     (q_pop),
		.item         (q_item),
		.mdu_req      (mdu_req),
		.mdu_rsp      (mdu_rsp),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	psc_mdu u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mdu_req),
		.rsp   (mdu_rsp)
	);

endmodule

// ===== rtl/psc_checker.sv =====
// ---------------------------------------------------------------------------
// psc_checker
// Port-level checks on the calculator's result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_checker import psc_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam bit DEPTH_FITS = (STACK_DEPTH < 128);

	logic [DATA_W-1:0]      top;
	logic [DEPTH_OUT_W-1:0] depth;
	logic [STAT_W-1:0]      status;

	assign top     = m_axis_tdata[DATA_W-1:0];
	assign depth   = m_axis_tdata[DATA_W +: DEPTH_OUT_W];
	assign status  = m_axis_tdata[DATA_W + DEPTH_OUT_W +: STAT_W];

	// stalled result holds
	`PSC_ASSERT_HOLD(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		({m_axis_tvalid, m_axis_tdata}))

	// only defined status codes
	`PSC_ASSERT_IMP(a_status_code, clk, arst_n, m_axis_tvalid,
		status == STAT_OK || status == STAT_UNDERFLOW || status == STAT_OVERFLOW ||
		status == STAT_DIVZERO || status == STAT_ZERONEG)

	// underflow only with fewer than two entries
	`PSC_ASSERT_IMP(a_underflow_depth, clk, arst_n,
		m_axis_tvalid && DEPTH_FITS && status == STAT_UNDERFLOW,
		depth < DEPTH_OUT_W'(2))

	// empty stack reads as zero
	`PSC_ASSERT_IMP(a_empty_zero, clk, arst_n,
		m_axis_tvalid && DEPTH_FITS && depth == '0,
		top == '0)

endmodule

bind postfix_integer_stack_calculator psc_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_psc_checker (.*);
